### rtl/scp_pkg.sv
// Shared types and constants for the SIEVE cache policy block.
// No dependencies; used by the channel interfaces, the top level and the testbench.
`default_nettype none
package scp_pkg;

  localparam int KEY_BITS     = 32;
  localparam int DATA_BITS    = 64;
  localparam int CAP_BITS     = 5;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int VALUE_BITS_DEF  = 64;
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;

  // Register index: capacity limit.
  localparam logic [0:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_GET_HIT  = 2'd0,
    ST_GET_MISS = 2'd1,
    ST_PUT_UPD  = 2'd2,
    ST_PUT_INS  = 2'd3
  } status_e;

endpackage
`default_nettype wire

### rtl/scp_if.sv
// Request and response channel interfaces (valid/ready with payload).
// Depends on scp_pkg for field widths.
`default_nettype none
interface scp_req_if;
  import scp_pkg::*;
  logic                operation;
  logic [KEY_BITS-1:0] lookup_key;
  logic [DATA_BITS-1:0] write_value;
  logic                valid;
  logic                ready;
  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface scp_rsp_if;
  import scp_pkg::*;
  logic [1:0]           status;
  logic [DATA_BITS-1:0] read_value;
  logic                 did_evict;
  logic [KEY_BITS-1:0]  evicted_key;
  logic                 valid;
  logic                 ready;
  modport source (output valid, status, read_value, did_evict, evicted_key, input ready);
  modport sink   (input valid, status, read_value, did_evict, evicted_key, output ready);
endinterface
`default_nettype wire

### rtl/sieve_cache_policy.sv
// SIEVE cache policy block: keys, values and insertion-order links in memories.
// Depends on scp_pkg and the channel interfaces in scp_if.sv.
//
// One request is handled at a time; a new request is taken only back in idle. The
// lookup reads and compares one slot at a time, a read state then a compare state,
// and stops at the first match, so a miss scans every slot. A get hit then reads
// the value. A put of a new key into a cache that is not full then inserts it. If
// the cache is full, the hand walks the visited bits first. Each set bit that it
// clears passes through the walk state and a step state that reads the next link,
// but the wrap from the newest to the oldest entry stays in the walk state. The
// victim's key and links are read, then it is unlinked and the new key inserted.
// The result is loaded into the output register, and waits while the previous
// beat is still waiting there. The block then returns to idle to take the next
// request. No clearing pass is needed after reset. Capacity is written over the
// APB port at byte address 0.
`default_nettype none
module sieve_cache_policy #(
  parameter int MAX_ENTRIES = scp_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = scp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  scp_req_if.sink                        req_i,
  scp_rsp_if.source                      rsp_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [scp_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [scp_pkg::PDATA_BITS-1:0] pwdata,
  output logic [scp_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import scp_pkg::*;

  localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CNTW > CAP_BITS) ? CNTW : CAP_BITS;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_ENTRIES - 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN_RD = 4'd1, S_SCAN_CMP = 4'd2,
                         S_GET_RD = 4'd3, S_WALK = 4'd4, S_WALK_NX = 4'd5,
                         S_EV_RD = 4'd6, S_EV_UN = 4'd7, S_INS = 4'd8,
                         S_RESULT = 4'd9;

  // Memories
  logic [KEY_BITS-1:0]   key_mem   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem   [MAX_ENTRIES];
  logic [IDXW-1:0]       older_mem [MAX_ENTRIES];
  logic [IDXW-1:0]       newer_mem [MAX_ENTRIES];

  logic                  key_re, key_we, val_re, val_we;
  logic                  older_re, older_we, newer_re, newer_we;
  logic [IDXW-1:0]       key_ra, key_wa, val_ra, val_wa;
  logic [IDXW-1:0]       older_ra, older_wa, newer_ra, newer_wa;
  logic [KEY_BITS-1:0]   key_wd, key_rd_q;
  logic [VALUE_BITS-1:0] val_wd, val_rd_q;
  logic [IDXW-1:0]       older_wd, older_rd_q, newer_wd, newer_rd_q;

  // Control and policy state
  logic [3:0]            state_q, state_d;
  logic [CAP_BITS-1:0]   cap_q;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d, visited_q, visited_d;
  logic [IDXW-1:0]       newest_q, newest_d, oldest_q, oldest_d;
  logic [IDXW-1:0]       hand_q, hand_d, cur_q, cur_d, idx_q, idx_d;
  logic                  hand_valid_q, hand_valid_d;
  logic [CNTW-1:0]       occ_q, occ_d;

  // Current request and result fields
  logic                  op_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_val_q;
  logic [1:0]            status_q, status_d;
  logic                  evict_q, evict_d;
  logic [KEY_BITS-1:0]   ekey_q, ekey_d;

  // Output register
  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [DATA_BITS-1:0]  out_value_q;
  logic                  out_evict_q;
  logic [KEY_BITS-1:0]   out_ekey_q;
  logic                  out_load;

  logic                  req_fire, cfg_wr, full_w;
  logic [IDXW-1:0]       free_w, next_w;
  logic [CMPW-1:0]       cap_ext, eff_cap;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_BITS'(cap_q) : '0;

  // Clamp capacity to 1..MAX_ENTRIES and test for a full cache
  always_comb begin
    cap_ext = CMPW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full_w = (CMPW'(occ_q) >= eff_cap) && (occ_q != '0);
  end

  // Lowest free slot
  always_comb begin
    free_w = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_w = IDXW'(i);
    end
  end

  assign next_w = (cur_q == newest_q) ? oldest_q : newer_rd_q;
  assign out_load = (state_q == S_RESULT) && (!out_valid_q || rsp_o.ready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    visited_d = visited_q;
    newest_d = newest_q;
    oldest_d = oldest_q;
    hand_d = hand_q;
    hand_valid_d = hand_valid_q;
    cur_d = cur_q;
    idx_d = idx_q;
    occ_d = occ_q;
    status_d = status_q;
    evict_d = evict_q;
    ekey_d = ekey_q;
    key_re = 1'b0; key_ra = idx_q; key_we = 1'b0; key_wa = free_w; key_wd = req_key_q;
    val_re = 1'b0; val_ra = idx_q; val_we = 1'b0; val_wa = idx_q; val_wd = req_val_q;
    older_re = 1'b0; older_ra = cur_q; older_we = 1'b0; older_wa = free_w;
    older_wd = newest_q;
    newer_re = 1'b0; newer_ra = cur_q; newer_we = 1'b0; newer_wa = newest_q;
    newer_wd = free_w;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          idx_d = '0;
          evict_d = 1'b0;
          ekey_d = '0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        key_re = 1'b1;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (valid_q[idx_q] && key_rd_q == req_key_q) begin
          // Hit: mark visited
          visited_d[idx_q] = 1'b1;
          if (op_q == OP_GET) begin
            status_d = ST_GET_HIT;
            state_d = S_GET_RD;
          end else begin
            val_we = 1'b1;
            status_d = ST_PUT_UPD;
            state_d = S_RESULT;
          end
        end else if (idx_q != LAST_IDX) begin
          idx_d = idx_q + IDXW'(1);
          state_d = S_SCAN_RD;
        end else if (op_q == OP_GET) begin
          status_d = ST_GET_MISS;
          state_d = S_RESULT;
        end else begin
          status_d = ST_PUT_INS;
          cur_d = hand_valid_q ? hand_q : oldest_q;
          state_d = full_w ? S_WALK : S_INS;
        end
      end
      S_GET_RD: begin
        val_re = 1'b1;
        state_d = S_RESULT;
      end
      S_WALK: begin
        // Clear set visited bits, advance toward newer entries
        if (visited_q[cur_q]) begin
          visited_d[cur_q] = 1'b0;
          if (cur_q == newest_q) begin
            cur_d = oldest_q;
          end else begin
            newer_re = 1'b1;
            state_d = S_WALK_NX;
          end
        end else begin
          key_re = 1'b1; key_ra = cur_q;
          older_re = 1'b1;
          newer_re = 1'b1;
          state_d = S_EV_RD;
        end
      end
      S_WALK_NX: begin
        cur_d = newer_rd_q;
        state_d = S_WALK;
      end
      S_EV_RD: begin
        state_d = S_EV_UN;
      end
      S_EV_UN: begin
        // Unlink the victim and park the hand after it
        evict_d = 1'b1;
        ekey_d = key_rd_q;
        if (cur_q == newest_q) begin
          newest_d = older_rd_q;
        end else begin
          older_we = 1'b1; older_wa = newer_rd_q; older_wd = older_rd_q;
        end
        if (cur_q == oldest_q) begin
          oldest_d = newer_rd_q;
        end else begin
          newer_we = 1'b1; newer_wa = older_rd_q; newer_wd = newer_rd_q;
        end
        valid_d[cur_q] = 1'b0;
        visited_d[cur_q] = 1'b0;
        occ_d = occ_q - CNTW'(1);
        if (occ_q == CNTW'(1)) begin
          hand_valid_d = 1'b0;
        end else begin
          hand_d = next_w;
          hand_valid_d = 1'b1;
        end
        state_d = S_INS;
      end
      S_INS: begin
        // Insert at the lowest free slot as the newest entry
        key_we = 1'b1;
        val_we = 1'b1; val_wa = free_w;
        valid_d[free_w] = 1'b1;
        visited_d[free_w] = 1'b0;
        if (occ_q == '0) begin
          oldest_d = free_w;
          hand_d = free_w;
          hand_valid_d = 1'b1;
        end else begin
          older_we = 1'b1;
          newer_we = 1'b1;
        end
        newest_d = free_w;
        occ_d = occ_q + CNTW'(1);
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (key_re) key_rd_q <= key_mem[key_ra];
  end
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (val_re) val_rd_q <= val_mem[val_ra];
  end
  always_ff @(posedge clk_i) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    if (older_re) older_rd_q <= older_mem[older_ra];
  end
  always_ff @(posedge clk_i) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (newer_re) newer_rd_q <= newer_mem[newer_ra];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q <= CAP_RESET;
      valid_q <= '0;
      visited_q <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      hand_q <= '0;
      hand_valid_q <= 1'b0;
      occ_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      visited_q <= visited_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      hand_q <= hand_d;
      hand_valid_q <= hand_valid_d;
      occ_q <= occ_d;
      if (cfg_wr && paddr[2] == REG_CAPACITY) cap_q <= pwdata[CAP_BITS-1:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: request capture, working fields, result beat
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    status_q <= status_d;
    evict_q <= evict_d;
    ekey_q <= ekey_d;
    if (req_fire) begin
      op_q <= req_i.operation;
      req_key_q <= req_i.lookup_key;
      req_val_q <= req_i.write_value[VALUE_BITS-1:0];
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_value_q <= (status_q == ST_GET_HIT) ? DATA_BITS'(val_rd_q) : '0;
      out_evict_q <= evict_q;
      out_ekey_q <= ekey_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.did_evict = out_evict_q;
  assign rsp_o.evicted_key = out_ekey_q;

  // Checks
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNTW'(MAX_ENTRIES) >= occ_q) else $error("occupancy above entry count");
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q)) else $error("occupancy and valid bits disagree");
  a_hand_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hand_valid_q && state_q == S_IDLE) |-> valid_q[hand_q])
    else $error("hand parked on a free slot");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE) else $error("result beat lost");

endmodule
`default_nettype wire

### verif/tb_sieve_cache_policy.sv
// Self-checking testbench for the SIEVE cache policy block.
// Depends on scp_pkg and the channel interfaces in scp_if.sv; predicts each beat in a class.
`timescale 1ns / 1ps

class sieve_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic        did_evict;
    logic [31:0] evicted_key;
  } outcome_t;

  logic [31:0] key_mem [16];
  logic [63:0] val_mem [16];
  bit          live [16];
  bit          seen [16];
  int          older [16];
  int          newer [16];
  int          head_new, tail_old, hand;
  bit          hand_ok;
  int          fill;
  int          cap_reg;
  outcome_t    pending [$];
  int          errors;

  function new();
    cap_reg = 16;
    hand_ok = 0;
    fill = 0;
    head_new = 0;
    tail_old = 0;
    hand = 0;
    errors = 0;
    foreach (live[i]) begin
      live[i] = 0;
      seen[i] = 0;
    end
  endfunction

  function int next_newer(int s);
    if (s == head_new) return tail_old;
    return newer[s];
  endfunction

  // Walk the hand, clearing visited bits, and drop the first unvisited entry.
  function logic [31:0] sweep_out();
    int cur, nxt, guard;
    logic [31:0] k;
    cur = hand_ok ? hand : tail_old;
    guard = 34;
    while (seen[cur] && guard > 0) begin
      seen[cur] = 0;
      cur = next_newer(cur);
      guard--;
    end
    nxt = next_newer(cur);
    k = key_mem[cur];
    if (cur == head_new) head_new = older[cur]; else older[newer[cur]] = older[cur];
    if (cur == tail_old) tail_old = newer[cur]; else newer[older[cur]] = newer[cur];
    live[cur] = 0;
    seen[cur] = 0;
    if (fill > 0) fill--;
    if (fill == 0) hand_ok = 0;
    else begin
      hand = nxt;
      hand_ok = 1;
    end
    return k;
  endfunction

  // Note an accepted request and queue its outcome.
  function void note_request(logic op, logic [31:0] k, logic [63:0] v);
    outcome_t o;
    int hit, s, cap;
    o = '0;
    hit = -1;
    for (int i = 15; i >= 0; i--) if (live[i] && key_mem[i] == k) hit = i;
    cap = (cap_reg == 0) ? 1 : (cap_reg > 16 ? 16 : cap_reg);
    if (op == scp_pkg::OP_GET) begin
      if (hit >= 0) begin
        seen[hit] = 1;
        o.read_value = val_mem[hit];
        o.status = scp_pkg::ST_GET_HIT;
      end else o.status = scp_pkg::ST_GET_MISS;
    end else if (hit >= 0) begin
      val_mem[hit] = v;
      seen[hit] = 1;
      o.status = scp_pkg::ST_PUT_UPD;
    end else begin
      if (fill >= cap && fill > 0) begin
        o.evicted_key = sweep_out();
        o.did_evict = 1;
      end
      s = 0;
      for (int i = 15; i >= 0; i--) if (!live[i]) s = i;
      key_mem[s] = k;
      val_mem[s] = v;
      live[s] = 1;
      seen[s] = 0;
      if (fill == 0) begin
        head_new = s;
        tail_old = s;
      end else begin
        older[s] = head_new;
        newer[head_new] = s;
        head_new = s;
      end
      fill++;
      if (fill == 1) begin
        hand = s;
        hand_ok = 1;
      end
      o.status = scp_pkg::ST_PUT_INS;
    end
    pending.push_back(o);
  endfunction

  // Compare one response beat against the oldest outcome.
  function void check_response(outcome_t got);
    outcome_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_sieve_cache_policy;
  import scp_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;

  scp_req_if req_if ();
  scp_rsp_if rsp_if ();

  sieve_cache_policy u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sieve_scoreboard board = new();
  bit calm = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    req_if.valid = 0;
    req_if.operation = 0;
    req_if.lookup_key = '0;
    req_if.write_value = '0;
    rsp_if.ready = 0;
  end

  always #5 clk_i = ~clk_i;

  // Sample response beats and stall the sink in bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        board.check_response({rsp_if.status, rsp_if.read_value, rsp_if.did_evict,
                              rsp_if.evicted_key});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_if.ready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= int'($urandom_range(0, 3));
        rsp_if.ready <= 0;
      end else rsp_if.ready <= 1;
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_sieve_cache_policy NOT OK");
      $finish;
    end
  end

  task automatic write_capacity(int cap);
    @(posedge clk_i);
    psel <= 1;
    pwrite <= 1;
    paddr <= PADDR_BITS'(4 * REG_CAPACITY);
    pwdata <= cap;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.cap_reg = cap & 5'h1f;
  endtask

  // Hold valid high across back-to-back calls; drop it only while idling.
  task automatic send_request(logic op, logic [31:0] k, logic [63:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.operation <= op;
    req_if.lookup_key <= k;
    req_if.write_value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(op, k, v);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_value();
    return {$urandom(), $urandom()};
  endfunction

  // Keys mostly from a small pool so hits and evictions are frequent.
  function automatic logic [31:0] pool_key(int span);
    int pick;
    pick = $urandom_range(0, span);
    if (pick == 0) return $urandom();
    return 32'h8000_0000 + pick;
  endfunction

  initial begin
    int caps [6] = '{0, 1, 31, 3, 17, 8};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes of keys and values, misses, updates, hits.
    send_request(OP_GET, 32'h0, 64'h0);
    send_request(OP_PUT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 64'h0);
    send_request(OP_PUT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
    send_request(OP_GET, 32'h8000_0000, 64'h1);
    send_request(OP_PUT, 32'h7FFF_FFFF, 64'hAAAA_5555_AAAA_5555);
    send_request(OP_GET, 32'h7FFF_FFFF, 64'h0);
    send_request(OP_GET, 32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    // Capacity one: every new key evicts an entry.
    write_capacity(1);
    send_request(OP_PUT, 32'h0000_0001, 64'h11);
    send_request(OP_GET, 32'h0000_0001, 64'h0);
    send_request(OP_PUT, 32'h0000_0002, 64'h22);
    send_request(OP_GET, 32'hFFFF_FFFF, 64'h0);
    drain();
    write_capacity(16);

    // Random phases with varied capacities, including zero and over-range.
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      for (int n = 0; n < 300; n++) begin
        if (n == 150) drain();
        send_request(1'($urandom_range(0, 1)), pool_key(caps[ph] + 6), rand_value());
      end
      drain();
    end

    // Closing stretch without idling.
    calm = 1;
    for (int n = 0; n < 100; n++)
      send_request(1'($urandom_range(0, 1)), pool_key(20), rand_value());
    drain();

    if (board.errors == 0) $display("tb_sieve_cache_policy OK");
    else $display("tb_sieve_cache_policy NOT OK");
    $finish;
  end
endmodule
